[rtl/dsa_pkg.sv]
// Shared types and constants for the decimating sample averager.
`timescale 1ns / 1ps

package dsa_pkg;

	// Field and register widths
	localparam int SAMPLE_BITS = 10;
	localparam int PERIOD_W    = 16;
	localparam int COUNT_W     = 6;
	localparam int MODE_W      = 2;
	localparam int ACC_W       = 16;
	localparam int STEP_W      = 4;   // holds divider step index 0..SAMPLE_BITS-1
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	// Register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd500;
	localparam logic [COUNT_W-1:0]  COUNT_RST  = 6'd16;
	localparam logic [MODE_W-1:0]   MODE_RST   = 2'd1;

	// Register indexes (word address)
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_PERIOD = 2'd0;
	localparam reg_idx_t REG_COUNT  = 2'd1;
	localparam reg_idx_t REG_MODE   = 2'd2;

	// Filter modes; the unused code behaves as pass-through
	localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

	typedef struct packed {
		logic [PERIOD_W-1:0] sample_period;
		logic [COUNT_W-1:0]  sample_count;
		logic [MODE_W-1:0]   filter_mode;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic tick_only;    // accepted tick, no sample due
		logic take_sample;  // accepted tick, sample taken, divider loaded
		logic div_step;     // one shift-subtract step
		logic update;       // fold quotient and sample into block state
		logic emit;         // load output register, restart block
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sample_due;
		logic div_last;
		logic block_done;
		logic out_free;
	} status_t;

endpackage

[rtl/dsa_channels.sv]
// Valid/ready channel interfaces for input ticks and filtered results.
`timescale 1ns / 1ps

interface dsa_in_if;
	logic                            valid;
	logic                            ready;
	logic [dsa_pkg::SAMPLE_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface dsa_out_if;
	logic                            valid;
	logic                            ready;
	logic [dsa_pkg::SAMPLE_BITS-1:0] filtered_value;

	modport source (output valid, output filtered_value, input ready);
	modport sink   (input valid, input filtered_value, output ready);
endinterface

[rtl/dsa_regs.sv]
// APB-style configuration register file.
`timescale 1ns / 1ps

module dsa_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsa_pkg::ADDR_W-1:0]   paddr,
	input  logic [dsa_pkg::DATA_W-1:0]   pwdata,
	output logic [dsa_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output dsa_pkg::cfg_t                cfg
);

	dsa_pkg::cfg_t     cfg_q;
	dsa_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period <= dsa_pkg::PERIOD_RST;
			cfg_q.sample_count  <= dsa_pkg::COUNT_RST;
			cfg_q.filter_mode   <= dsa_pkg::MODE_RST;
		end else if (wr_en) begin
			case (idx)
				dsa_pkg::REG_PERIOD: cfg_q.sample_period <= pwdata[dsa_pkg::PERIOD_W-1:0];
				dsa_pkg::REG_COUNT:  cfg_q.sample_count  <= pwdata[dsa_pkg::COUNT_W-1:0];
				dsa_pkg::REG_MODE:   cfg_q.filter_mode   <= pwdata[dsa_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			dsa_pkg::REG_PERIOD: prdata = dsa_pkg::DATA_W'(cfg_q.sample_period);
			dsa_pkg::REG_COUNT:  prdata = dsa_pkg::DATA_W'(cfg_q.sample_count);
			dsa_pkg::REG_MODE:   prdata = dsa_pkg::DATA_W'(cfg_q.filter_mode);
			default:             prdata = '0;
		endcase
	end

endmodule

[rtl/dsa_ctrl.sv]
// Sequencing state machine: accept, divide, update, emit.
`timescale 1ns / 1ps

module dsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dsa_pkg::status_t  status,
	output dsa_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (status.sample_due) begin
						cmd.take_sample = 1'b1;
						state_d         = ST_DIV;
					end else begin
						cmd.tick_only = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = status.block_done ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/dsa_datapath.sv]
// Tick counter, shift-subtract divider, block state and output register.
`timescale 1ns / 1ps

module dsa_datapath #(
	parameter int MAX_SAMPLES = 32,
	parameter int MIN_PERIOD  = 1,
	parameter int MAX_PERIOD  = 65535
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dsa_pkg::cfg_t                    cfg,
	input  dsa_pkg::cmd_t                    cmd,
	output dsa_pkg::status_t                 status,
	input  logic [dsa_pkg::SAMPLE_BITS-1:0]  in_sample,
	output logic                             out_valid,
	output logic [dsa_pkg::SAMPLE_BITS-1:0]  out_value,
	input  logic                             out_ready
);

	localparam int SB = dsa_pkg::SAMPLE_BITS;
	localparam int CW = dsa_pkg::COUNT_W;

	logic [dsa_pkg::PERIOD_W-1:0] tick_count_q, tick_next, period_eff;
	logic [CW-1:0]                count_eff, samples_taken_q, div_d_q, rem_q;
	logic [CW:0]                  rem_sh, samples_next;
	logic [SB-1:0]                quo_q, sample_q, latest_q, run_q, out_data_q, result;
	logic [SB:0]                  run_sum;
	logic [dsa_pkg::ACC_W-1:0]    acc_q;
	logic [dsa_pkg::STEP_W-1:0]   step_q;
	logic                         out_valid_q;

	// Clamped period and count
	always_comb begin
		period_eff = cfg.sample_period;
		if (32'(cfg.sample_period) < MIN_PERIOD) period_eff = dsa_pkg::PERIOD_W'(MIN_PERIOD);
		if (32'(cfg.sample_period) > MAX_PERIOD) period_eff = dsa_pkg::PERIOD_W'(MAX_PERIOD);
		count_eff = cfg.sample_count;
		if (cfg.sample_count == '0) count_eff = CW'(1);
		if (32'(cfg.sample_count) > MAX_SAMPLES) count_eff = CW'(MAX_SAMPLES);
	end

	assign tick_next    = tick_count_q + 1'b1;
	assign rem_sh       = {rem_q, quo_q[SB-1]};
	assign samples_next = {1'b0, samples_taken_q} + 1'b1;
	assign run_sum      = {1'b0, run_q} + {1'b0, sample_q};

	// Result selection by mode
	always_comb begin
		case (cfg.filter_mode)
			dsa_pkg::MODE_AVG:
				result = (acc_q > dsa_pkg::ACC_W'(dsa_pkg::SAMPLE_MAX)) ?
					dsa_pkg::SAMPLE_MAX : acc_q[SB-1:0];
			dsa_pkg::MODE_RUN: result = run_q;
			default:           result = latest_q;
		endcase
	end

	assign status.sample_due = tick_next >= period_eff;
	assign status.div_last   = step_q == dsa_pkg::STEP_W'(SB - 1);
	assign status.block_done = samples_next >= {1'b0, count_eff};
	assign status.out_free   = !out_valid_q || out_ready;

	// Tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (cmd.take_sample) begin
			tick_count_q <= '0;
		end else if (cmd.tick_only) begin
			tick_count_q <= tick_next;
		end
	end

	// Restoring divider: sample / clamped count, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			sample_q <= in_sample;
			quo_q    <= in_sample;
			rem_q    <= '0;
			div_d_q  <= count_eff;
			step_q   <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
			if (rem_sh >= {1'b0, div_d_q}) begin
				rem_q <= CW'(rem_sh - {1'b0, div_d_q});
				quo_q <= {quo_q[SB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CW-1:0];
				quo_q <= {quo_q[SB-2:0], 1'b0};
			end
		end
	end

	// Block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_taken_q <= '0;
			acc_q           <= '0;
			latest_q        <= '0;
			run_q           <= '0;
		end else if (cmd.update) begin
			samples_taken_q <= samples_next[CW-1:0];
			acc_q           <= acc_q + dsa_pkg::ACC_W'(quo_q);
			latest_q        <= sample_q;
			run_q           <= run_sum[SB:1];
		end else if (cmd.emit) begin
			samples_taken_q <= '0;
			acc_q           <= '0;
			run_q           <= result;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_data_q;

endmodule

[rtl/decimating_sample_averager.sv]
// Decimating sample averager: top level.
`timescale 1ns / 1ps

// Each input transaction is one timer tick carrying a 10-bit converter value. A tick on
// which no sample is due is accepted in the idle state without leaving it, so such ticks
// can arrive back to back. A tick that takes a sample occupies the block through the
// accept, the one-bit-per-cycle restoring divider that forms sample / count and the
// update of the block state. A tick whose sample completes a block then loads the
// output register; that step waits while an earlier result
// still sits unread in the output register. Results are presented from that register,
// so the next tick is accepted while one waits.
// Registers: 0x0 sample_period, 0x4 sample_count, 0x8 filter_mode; write them only
// while the block is idle.
module decimating_sample_averager #(
	parameter int MAX_SAMPLES = 32,
	parameter int MIN_PERIOD  = 1,
	parameter int MAX_PERIOD  = 65535
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsa_pkg::ADDR_W-1:0]   paddr,
	input  logic [dsa_pkg::DATA_W-1:0]   pwdata,
	output logic [dsa_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	dsa_in_if.sink                       in_ch,
	dsa_out_if.source                    out_ch
);

	dsa_pkg::cfg_t    cfg;
	dsa_pkg::cmd_t    cmd;
	dsa_pkg::status_t status;

	dsa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dsa_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MIN_PERIOD  (MIN_PERIOD),
		.MAX_PERIOD  (MAX_PERIOD)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.in_sample (in_ch.adc_sample),
		.out_valid (out_ch.valid),
		.out_value (out_ch.filtered_value),
		.out_ready (out_ch.ready)
	);

endmodule

[verif/decimating_sample_averager_checker.sv]
// Prediction and result checking for the decimating sample averager testbench.
`timescale 1ns / 1ps

module decimating_sample_averager_checker #(
	parameter int MAX_SAMPLES = 32,
	parameter int MIN_PERIOD  = 1,
	parameter int MAX_PERIOD  = 65535
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dsa_pkg::ADDR_W-1:0]  paddr,
	input  logic [dsa_pkg::DATA_W-1:0]  pwdata,
	input  logic                        pready,
	dsa_in_if                           in_mon,
	dsa_out_if                          out_mon,
	output int                          error_count,
	output int                          pending
);
	import dsa_pkg::*;

	// Mirror of the configuration registers
	logic [PERIOD_W-1:0] cur_period;
	logic [COUNT_W-1:0]  cur_count;
	logic [MODE_W-1:0]   cur_mode;

	// Filter state
	logic [PERIOD_W-1:0]    ticks_since_sample;
	logic [COUNT_W-1:0]     samples_in_block;
	logic [ACC_W-1:0]       block_sum;
	logic [SAMPLE_BITS-1:0] last_sample;
	logic [SAMPLE_BITS-1:0] halving_value;

	// Filtered values still owed by the block, oldest first
	logic [SAMPLE_BITS-1:0] owed_values[$];

	assign pending = owed_values.size();

	// Advance the filter by one tick; queue a filtered value when a block completes
	task automatic filter_tick(input logic [SAMPLE_BITS-1:0] s);
		int                     period_eff;
		int                     count_eff;
		int                     halved;
		logic [SAMPLE_BITS-1:0] value;
		period_eff = cur_period;
		if (period_eff < MIN_PERIOD) period_eff = MIN_PERIOD;
		if (period_eff > MAX_PERIOD) period_eff = MAX_PERIOD;
		ticks_since_sample = ticks_since_sample + 1'b1;
		if (ticks_since_sample >= period_eff) begin
			ticks_since_sample = '0;
			count_eff = cur_count;
			if (count_eff < 1) count_eff = 1;
			if (count_eff > MAX_SAMPLES) count_eff = MAX_SAMPLES;
			last_sample = s;
			block_sum = block_sum + ACC_W'(int'(s) / count_eff);
			halved = (int'(halving_value) + int'(s)) >> 1;
			halving_value = halved[SAMPLE_BITS-1:0];
			samples_in_block = samples_in_block + 1'b1;
			if (samples_in_block >= count_eff) begin
				case (cur_mode)
					MODE_AVG: begin
						// average can exceed the sample range after a count change
						value = (block_sum > ACC_W'(SAMPLE_MAX)) ? SAMPLE_MAX
							: block_sum[SAMPLE_BITS-1:0];
					end
					MODE_RUN: value = halving_value;
					default: value = last_sample;
				endcase
				samples_in_block = '0;
				block_sum = '0;
				halving_value = value;
				owed_values.push_back(value);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_period = PERIOD_RST;
			cur_count = COUNT_RST;
			cur_mode = MODE_RST;
			ticks_since_sample = '0;
			samples_in_block = '0;
			block_sum = '0;
			last_sample = '0;
			halving_value = '0;
			owed_values.delete();
			error_count = 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_PERIOD: cur_period = pwdata[PERIOD_W-1:0];
					REG_COUNT:  cur_count = pwdata[COUNT_W-1:0];
					REG_MODE:   cur_mode = pwdata[MODE_W-1:0];
					default: ;
				endcase
			end
			// input transaction
			if (in_mon.valid && in_mon.ready)
				filter_tick(in_mon.adc_sample);
			// output transaction
			if (out_mon.valid && out_mon.ready) begin
				if (owed_values.size() == 0) begin
					$error("filtered_value: no result expected, actual %0d",
						out_mon.filtered_value);
					error_count++;
				end else if (out_mon.filtered_value !== owed_values[0]) begin
					$error("filtered_value: expected %0d, actual %0d",
						owed_values[0], out_mon.filtered_value);
					error_count++;
					void'(owed_values.pop_front());
				end else begin
					void'(owed_values.pop_front());
				end
			end
		end
	end

endmodule

[verif/decimating_sample_averager_tb.sv]
// Testbench top for the decimating sample averager: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module decimating_sample_averager_tb;
	import dsa_pkg::*;

	localparam int               CYCLE_LIMIT  = 1000000;
	localparam int               SETTLE_TICKS = 20;     // lets a sampling tick in flight settle
	localparam int               RAND_PHASES  = 10;
	localparam int               PHASE_TICKS  = 125;
	localparam int               LONG_TICKS   = 20;
	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;   // unused code, acts as pass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int tx_idle_pct;
	int rx_stall_pct;
	int cycles;
	int error_count;
	int pending;

	dsa_in_if  in_ch ();
	dsa_out_if out_ch ();

	decimating_sample_averager DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	decimating_sample_averager_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.error_count (error_count),
		.pending     (pending)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("decimating_sample_averager_tb: errors");
			$finish;
		end
	end

	// Result side backpressure
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Converter value biased toward the range ends
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return SAMPLE_MAX;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// One tick transaction; entered and left at a falling edge
	task automatic send_tick(input logic [SAMPLE_BITS-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.adc_sample <= SAMPLE_BITS'($urandom);
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.adc_sample <= value;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// One register write; entered and left at a falling edge, bus idle before it returns
	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Stop ticks, collect every owed result, then let an unfinished sample settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		rx_stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic configure(input int period, input int count, input logic [MODE_W-1:0] mode);
		drain();
		reg_write(REG_PERIOD, DATA_W'(period));
		reg_write(REG_COUNT, DATA_W'(count));
		reg_write(REG_MODE, DATA_W'(mode));
	endtask

	initial begin
		int period;
		int count;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.adc_sample = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pass latest at both range ends
		configure(1, 1, MODE_PASS);
		send_tick('0);
		send_tick(SAMPLE_MAX);

		// block average
		configure(1, 2, MODE_AVG);
		send_tick(SAMPLE_MAX);
		send_tick(SAMPLE_MAX);
		send_tick('0);
		send_tick(10'd1);

		// running halving with period zero
		configure(0, 2, MODE_RUN);
		send_tick(SAMPLE_MAX);
		send_tick(SAMPLE_MAX);

		// spare mode code with count zero
		configure(1, 0, MODE_SPARE);
		send_tick(10'd600);

		// partial block, then count drops: average saturates
		configure(1, 4, MODE_AVG);
		repeat (3) send_tick(SAMPLE_MAX);
		configure(1, 1, MODE_AVG);
		send_tick(SAMPLE_MAX);

		// period shortened while waiting for a sample
		configure(10, 1, MODE_PASS);
		repeat (5) send_tick(pick_sample());
		configure(2, 1, MODE_PASS);
		send_tick(10'd345);

		// longest period: no sample due; the next phase shortens it mid-wait
		configure(65535, 1, MODE_PASS);
		repeat (LONG_TICKS) send_tick(pick_sample());

		// random phases over all pacing modes
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(7))
				0: period = 0;
				1: period = $urandom_range(4, 12);
				default: period = $urandom_range(1, 3);
			endcase
			case ($urandom_range(9))
				0: count = 0;
				1: count = 32;
				2: count = $urandom_range(33, 63);
				3: count = $urandom_range(7, 31);
				default: count = $urandom_range(1, 6);
			endcase
			configure(period, count, MODE_W'($urandom_range(3)));
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
				default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
			endcase
			repeat (PHASE_TICKS) send_tick(pick_sample());
		end

		tx_idle_pct = 0;
		drain();
		if (error_count == 0)
			$display("decimating_sample_averager_tb: clean");
		else
			$display("decimating_sample_averager_tb: errors");
		$finish;
	end

endmodule
